// File: src/dib_pkg.sv
// shared types and constants for the double to bcd converter
// no dependencies; used by dib_cell and double_integer_part_to_bcd_core
package dib_pkg;

  localparam int unsigned MANT_BITS  = 52;
  localparam int unsigned EXP_FIELD  = 11;
  localparam int unsigned EXP_W      = 12;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned OUT_DIGITS = 16;
  localparam int unsigned CNT_W      = 6;

  localparam logic [EXP_FIELD-1:0] EXP_BIAS    = 11'd1023;
  localparam logic [EXP_FIELD-1:0] EXP_ALL_ONE = 11'h7ff;
  // largest biased exponent whose integer part still fits the mantissa
  localparam logic [EXP_FIELD-1:0] EXP_MAX_OK  = 11'd1075;

  localparam logic [DIGIT_W-1:0] DIGIT_HALF = 4'd5;
  localparam logic [DIGIT_W:0]   DIGIT_TEN  = 5'd10;

  // per-step control broadcast to every cell of the chain
  typedef struct packed {
    logic load;
    logic step;
  } cell_ctrl_t;

endpackage

// File: src/double_integer_part_to_bcd_core.sv
// top level: decodes a double, runs the bcd doubling chain, holds the result
// depends on dib_pkg and dib_cell
//
// Takes a raw 64-bit IEEE-754 double and returns its sign, unbiased exponent
// and the integer part of its magnitude as 16 packed BCD digits. One
// transaction at a time runs through a row of DIGITS digit cells, one
// doubling per exponent step (e being the unbiased exponent, 0..52); a
// negative or out-of-range exponent takes no step. The result goes to the
// output register once the steps are done and that register is free. The
// next item is taken from the cycle after the chain has handed its result to
// the output register, which may still be waiting on the far side, so no new
// item is taken before the chain is through with the last one.
// Exponents above 52, inf and NaN raise overflow with zero digits; negative
// exponents give zero.
module double_integer_part_to_bcd_core #(
  parameter int unsigned DIGITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [63:0]        float_bits_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               negative_o,
  output logic signed [11:0] unbiased_exponent_o,
  output logic [31:0]        digits_high_o,
  output logic [31:0]        digits_low_o,
  output logic               overflow_o
);

  localparam int unsigned DW = dib_pkg::DIGIT_W;
  localparam int unsigned MB = dib_pkg::MANT_BITS;
  localparam int unsigned HALF = dib_pkg::OUT_DIGITS / 2;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;
  logic [dib_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [MB-1:0] frac_q, frac_d;
  logic neg_q, ovf_q;
  logic [dib_pkg::EXP_W-1:0] exp_q;
  logic out_valid_q, out_valid_d;
  logic out_neg_q, out_ovf_q;
  logic [dib_pkg::EXP_W-1:0] out_exp_q;
  logic [31:0] out_hi_q, out_lo_q;

  logic in_accept, xfer, start_run;
  logic [dib_pkg::EXP_FIELD-1:0] biased;
  logic [dib_pkg::EXP_W-1:0] exp_val;
  logic in_ovf;
  dib_pkg::cell_ctrl_t ctrl;
  logic [DIGITS:0] carry;
  logic [DIGITS-1:0][DW-1:0] digit_w;

  assign in_stall_o = (state_q == ST_RUN);
  assign in_accept  = in_valid_i && !in_stall_o;

  // field decode at the input handshake
  assign biased    = float_bits_i[62:52];
  assign exp_val   = {1'b0, biased} - {1'b0, dib_pkg::EXP_BIAS};
  assign in_ovf    = (biased == dib_pkg::EXP_ALL_ONE) || (biased > dib_pkg::EXP_MAX_OK);
  assign start_run = !in_ovf && (biased >= dib_pkg::EXP_BIAS);

  assign xfer = (state_q == ST_RUN) && (cnt_q == '0) && (!out_valid_q || !out_stall_i);

  assign ctrl.load = in_accept;
  assign ctrl.step = (state_q == ST_RUN) && (cnt_q != '0);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    frac_d  = frac_q;
    if (in_accept) begin
      state_d = ST_RUN;
      cnt_d   = start_run ? exp_val[dib_pkg::CNT_W-1:0] : '0;
      frac_d  = float_bits_i[MB-1:0];
    end else if (ctrl.step) begin
      cnt_d  = cnt_q - 1'b1;
      frac_d = {frac_q[MB-2:0], 1'b0};
    end else if (xfer) begin
      state_d = ST_IDLE;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (xfer) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    frac_q <= frac_d;
    if (in_accept) begin
      neg_q <= float_bits_i[63];
      exp_q <= exp_val;
      ovf_q <= in_ovf;
    end
    if (xfer) begin
      out_neg_q <= neg_q;
      out_exp_q <= exp_q;
      out_ovf_q <= ovf_q;
      out_hi_q  <= digit_w[dib_pkg::OUT_DIGITS-1:HALF];
      out_lo_q  <= digit_w[HALF-1:0];
    end
  end

  // next mantissa bit enters at the least significant digit
  assign carry[0] = frac_q[MB-1];

  for (genvar gi = 0; gi < DIGITS; gi++) begin : g_cell
    logic [DW-1:0] load_digit;
    if (gi == 0) begin : g_first
      assign load_digit = {{(DW-1){1'b0}}, start_run};
    end else begin : g_rest
      assign load_digit = '0;
    end
    dib_cell u_cell (
      .clk_i        (clk_i),
      .ctrl_i       (ctrl),
      .load_digit_i (load_digit),
      .carry_i      (carry[gi]),
      .carry_o      (carry[gi+1]),
      .digit_o      (digit_w[gi])
    );
  end

  assign out_valid_o         = out_valid_q;
  assign negative_o          = out_neg_q;
  assign unbiased_exponent_o = out_exp_q;
  assign digits_high_o       = out_hi_q;
  assign digits_low_o        = out_lo_q;
  assign overflow_o          = out_ovf_q;

`ifndef SYNTHESIS
  a_step_count_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.step |=> (cnt_q == $past(cnt_q) - 1'b1))
    else $error("step counter did not count down");

  a_idle_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (cnt_q == '0))
    else $error("step counter nonzero while idle");

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (state_q == ST_RUN))
    else $error("accepted transaction did not start the chain");

  a_xfer_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer |=> out_valid_o)
    else $error("finished transaction did not reach the output");

  a_no_top_carry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.step |-> !carry[DIGITS])
    else $error("carry out of the top digit");
`endif

endmodule

// File: src/dib_cell.sv
// one decimal digit of the doubling chain: digit = 2 * digit + carry in, less ten when carry out is set
// depends on dib_pkg
module dib_cell (
  input  logic                               clk_i,
  input  dib_pkg::cell_ctrl_t                ctrl_i,
  input  logic [dib_pkg::DIGIT_W-1:0]        load_digit_i,
  input  logic                               carry_i,
  output logic                               carry_o,
  output logic [dib_pkg::DIGIT_W-1:0]        digit_o
);

  logic [dib_pkg::DIGIT_W-1:0] digit_q, digit_d;
  logic [dib_pkg::DIGIT_W:0]   dbl;

  // carry out does not depend on carry in: 2d + 1 >= 10 exactly when d >= 5
  assign carry_o = (digit_q >= dib_pkg::DIGIT_HALF);
  assign dbl     = {digit_q, carry_i};

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.load) begin
      digit_d = load_digit_i;
    end else if (ctrl_i.step) begin
      if (carry_o) begin
        digit_d = dib_pkg::DIGIT_W'(dbl - dib_pkg::DIGIT_TEN);
      end else begin
        digit_d = dbl[dib_pkg::DIGIT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign digit_o = digit_q;

endmodule

// File: tb/tb_top.sv
// self-checking testbench for double_integer_part_to_bcd_core
// depends on dib_pkg and the core; a scoreboard decodes each double
// independently and checks every result transaction field by field
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 60;
  localparam int unsigned RANDOM_PER_PHASE = 320;
  localparam int unsigned N_PHASES = 4;
  // sender idle and receiver stall percentages per phase
  localparam int unsigned IDLE_PCT [N_PHASES]  = '{0, 68, 0, 9};
  localparam int unsigned STALL_PCT [N_PHASES] = '{0, 0, 68, 9};

  localparam int unsigned N_CORNERS = 22;
  localparam logic [63:0] CORNER_DOUBLES [N_CORNERS] = '{
    64'h0000_0000_0000_0000, // +0
    64'h8000_0000_0000_0000, // -0
    64'h0000_0000_0000_0001, // smallest subnormal
    64'h000F_FFFF_FFFF_FFFF, // largest subnormal
    64'h3FE0_0000_0000_0000, // 0.5
    64'h3FEF_FFFF_FFFF_FFFF, // just under one
    64'h3FF0_0000_0000_0000, // exactly one, hidden bit only
    64'hBFF8_0000_0000_0000, // -1.5
    64'h3FFF_FFFF_FFFF_FFFF, // just under two
    64'h4000_0000_0000_0000, // 2.0
    64'h4024_0000_0000_0000, // 10.0
    64'h4058_FFFF_FFFF_FFFF, // just under 100
    64'h412E_8480_0000_0000, // 1e6
    64'h432F_FFFF_FFFF_FFFF, // exponent 51, fraction all ones
    64'h4330_0000_0000_0000, // 2^52
    64'hC33F_FFFF_FFFF_FFFF, // -(2^53 - 1), largest integer part
    64'h4340_0000_0000_0000, // 2^53, first exponent out of range
    64'h7FEF_FFFF_FFFF_FFFF, // largest finite
    64'h7FF0_0000_0000_0000, // +inf
    64'hFFF0_0000_0000_0000, // -inf
    64'h7FF8_0000_0000_0001, // nan
    64'hFFFF_FFFF_FFFF_FFFF  // nan, every bit set
  };

  typedef struct packed {
    logic               negative;
    logic signed [11:0] exponent;
    logic [31:0]        digits_high;
    logic [31:0]        digits_low;
    logic               overflow;
  } double_parts_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [63:0]        float_bits_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic               negative_o;
  logic signed [11:0] unbiased_exponent_o;
  logic [31:0]        digits_high_o;
  logic [31:0]        digits_low_o;
  logic               overflow_o;

  logic [63:0]   pending_doubles[$];
  double_parts_t expected_parts[$];

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned n_errors = 0;
  int unsigned n_checked = 0;
  int unsigned n_overflow = 0;
  int unsigned n_zero = 0;
  int unsigned n_negative = 0;
  int unsigned cycle_count = 0;

  double_integer_part_to_bcd_core dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .float_bits_i        (float_bits_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .negative_o          (negative_o),
    .unbiased_exponent_o (unbiased_exponent_o),
    .digits_high_o       (digits_high_o),
    .digits_low_o        (digits_low_o),
    .overflow_o          (overflow_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sign, exponent and floor(|x|) in packed bcd, by plain division
  function automatic double_parts_t decode_double(logic [63:0] bits);
    double_parts_t parts;
    int            e;
    int            i;
    logic [63:0]   magnitude;
    logic [63:0]   bcd;
    e = int'(bits[62:52]) - int'(dib_pkg::EXP_BIAS);
    parts.negative = bits[63];
    parts.exponent = e[11:0];
    parts.overflow = (bits[62:52] == dib_pkg::EXP_ALL_ONE) ||
                     (e > int'(dib_pkg::MANT_BITS));
    bcd = '0;
    if (!parts.overflow && e >= 0) begin
      magnitude = {11'd0, 1'b1, bits[51:0]} >> (int'(dib_pkg::MANT_BITS) - e);
      for (i = 0; i < int'(dib_pkg::OUT_DIGITS); i++) begin
        bcd[4*i +: 4] = 4'(magnitude % 64'd10);
        magnitude = magnitude / 64'd10;
      end
    end
    parts.digits_high = bcd[63:32];
    parts.digits_low  = bcd[31:0];
    return parts;
  endfunction

  // mostly in-range exponents so the doubling chain runs deep
  function automatic logic [63:0] random_double();
    int unsigned pick;
    logic [10:0] biased;
    logic [63:0] raw;
    pick = $urandom_range(99, 0);
    raw  = {$urandom, $urandom};
    if (pick < 70) begin
      biased = 11'(int'(dib_pkg::EXP_BIAS) + $urandom_range(int'(dib_pkg::MANT_BITS), 0));
    end else if (pick < 80) begin
      biased = 11'($urandom_range(2046, int'(dib_pkg::EXP_MAX_OK) + 1));
    end else if (pick < 85) begin
      biased = dib_pkg::EXP_ALL_ONE;
    end else if (pick < 95) begin
      biased = 11'($urandom_range(int'(dib_pkg::EXP_BIAS) - 1, 0));
    end else begin
      biased = raw[62:52];
    end
    return {raw[63], biased, raw[51:0]};
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    n_errors++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, want);
  endtask

  // input side: the expectation is recorded when the transaction is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i   <= 1'b0;
      float_bits_i <= '0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (in_valid_i) expected_parts.push_back(decode_double(float_bits_i));
      if (pending_doubles.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
        in_valid_i   <= 1'b1;
        float_bits_i <= pending_doubles.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side
  always @(posedge clk_i or negedge rst_ni) begin
    double_parts_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_parts.size() == 0) begin
          report_mismatch("unexpected transaction", {63'd0, out_valid_o}, 64'd0);
        end else begin
          want = expected_parts.pop_front();
          n_checked++;
          if (want.overflow) n_overflow++;
          else if (want.digits_high == '0 && want.digits_low == '0) n_zero++;
          if (want.negative) n_negative++;
          if (negative_o !== want.negative)
            report_mismatch("negative", 64'(negative_o), 64'(want.negative));
          if (unbiased_exponent_o !== want.exponent)
            report_mismatch("unbiased_exponent", 64'(unbiased_exponent_o),
                            64'(want.exponent));
          if (digits_high_o !== want.digits_high)
            report_mismatch("digits_high", 64'(digits_high_o), 64'(want.digits_high));
          if (digits_low_o !== want.digits_low)
            report_mismatch("digits_low", 64'(digits_low_o), 64'(want.digits_low));
          if (overflow_o !== want.overflow)
            report_mismatch("overflow", 64'(overflow_o), 64'(want.overflow));
        end
      end
      out_stall_i <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[%0t] timeout after %0d cycles", $time, cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int p;
    int k;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (p = 0; p < int'(N_PHASES); p++) begin
      idle_pct  = IDLE_PCT[p];
      stall_pct = STALL_PCT[p];
      if (p == 0) begin
        for (k = 0; k < int'(N_CORNERS); k++) pending_doubles.push_back(CORNER_DOUBLES[k]);
      end
      repeat (RANDOM_PER_PHASE) pending_doubles.push_back(random_double());
      // hold off until the core has drained every transaction of this phase
      while (pending_doubles.size() != 0 || in_valid_i || expected_parts.size() != 0)
        @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("checked %0d results over %0d idle/stall phases", n_checked, N_PHASES);
    $display("%0d negative, %0d overflow, %0d with a zero integer part",
             n_negative, n_overflow, n_zero);
    if (n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
src/dib_pkg.sv
src/dib_cell.sv
src/double_integer_part_to_bcd_core.sv
tb/tb_top.sv
